// ===== sv/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants of the radio strobing sequencer
// Event codes, radio commands, configuration indexes and the structs that
// travel between the sequencer's modules.
// ----------------------------------------------------------------------------
package rss_pkg;

  // Largest number of sequence indexes that the reception bitmap can log.
  localparam int unsigned MaxSeqCountDefault = 256;
  // Bytes in the reported bitmap window and its width in bits.
  localparam int unsigned MapBytes = 32;
  localparam int unsigned MapBits  = MapBytes * 8;
  // Length of the packet header in bytes.
  localparam logic [7:0]  HeaderLen = 8'd1;

  // Configuration reset values.
  localparam logic [7:0] HeaderByteReset    = 8'd0;
  localparam logic [7:0] MaxPayloadLenReset = 8'd64;
  localparam logic       CounterInFirstReset = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CfgHeaderByte    = 2'd0;
  localparam logic [1:0] CfgMaxPayloadLen = 2'd1;
  localparam logic [1:0] CfgCounterFirst  = 2'd2;

  typedef enum logic [2:0] {
    ACT_START      = 3'd0,
    ACT_STOP       = 3'd1,
    ACT_RX_STARTED = 3'd2,
    ACT_HEADER_RX  = 3'd3,
    ACT_RX_ENDED   = 3'd4,
    ACT_TX_ENDED   = 3'd5,
    ACT_RXTX_ERROR = 3'd6,
    ACT_RX_FAILED  = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_TX       = 3'd1,
    CMD_RX       = 3'd2,
    CMD_FLUSH_TX = 3'd3,
    CMD_FLUSH_RX = 3'd4,
    CMD_SLEEP    = 3'd5
  } cmd_e;

  // One input event.
  typedef struct packed {
    action_e    action;
    logic       tx_role;
    logic [7:0] length;
    logic [7:0] header_value;
    logic [7:0] sequence_value;
    logic [7:0] tx_goal;
    logic [4:0] map_byte_index;
  } item_t;

  // Configuration register file.
  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] max_payload_len;
    logic       counter_in_first_byte;
  } cfg_t;

  // Status and command of one event, bitmap byte excluded.
  typedef struct packed {
    cmd_e       radio_command;
    logic [7:0] sequence_out;
    logic       session_active;
    logic [7:0] rx_count;
    logic [7:0] rx_try_count;
    logic [7:0] tx_count;
    logic [7:0] payload_length;
    logic       rx_rejected;
    logic       store_payload;
  } status_t;

  // Bitmap update request from the control logic.
  typedef struct packed {
    logic       clear;
    logic       set;
    logic [7:0] set_index;
  } map_ctl_t;

endpackage

// ===== sv/radio_strobing_sequencer.sv =====
// ----------------------------------------------------------------------------
// radio_strobing_sequencer: packet-strobing session sequencer
// Turns radio and control events into radio commands and session status.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the in channel (valid/ready); each event yields exactly
//   one result on the out channel (valid/ready), in order.
//   An accepted event is held in an input register; the first later clock
//   edge on which the output register is free runs it through the session
//   logic and loads the output register, which then raises out_valid_o.
//   One event is accepted per cycle while results are taken. If the
//   receiver stalls, the output register holds its result and the input
//   register takes one more event; in_ready_o then drops until the
//   receiver takes the waiting result.
//   Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i, one
//   register per cycle, while no event is in flight; indexes past the last
//   register are ignored.
//   Reset clears the session state, the counters and the reception bitmap
//   and loads the configuration defaults; both channels come up empty.
// ----------------------------------------------------------------------------
module radio_strobing_sequencer #(
  parameter int unsigned MAX_SEQUENCE_COUNT = rss_pkg::MaxSeqCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // Event channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic       tx_role_i,
  input  logic [7:0] length_i,
  input  logic [7:0] header_value_i,
  input  logic [7:0] sequence_value_i,
  input  logic [7:0] tx_goal_i,
  input  logic [4:0] map_byte_index_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] radio_command_o,
  output logic [7:0] sequence_out_o,
  output logic       session_active_o,
  output logic [7:0] rx_count_o,
  output logic [7:0] rx_try_count_o,
  output logic [7:0] tx_count_o,
  output logic [7:0] payload_length_o,
  output logic       rx_rejected_o,
  output logic       store_payload_o,
  output logic [7:0] map_byte_o
);

  rss_pkg::cfg_t     cfg_q;
  rss_pkg::item_t    item_q;
  logic              item_valid_q;
  logic              out_valid_q;
  logic              advance;
  rss_pkg::status_t  status;
  rss_pkg::status_t  status_q;
  rss_pkg::map_ctl_t map_ctl;
  logic [7:0]        map_byte;
  logic [7:0]        map_byte_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte           <= rss_pkg::HeaderByteReset;
      cfg_q.max_payload_len       <= rss_pkg::MaxPayloadLenReset;
      cfg_q.counter_in_first_byte <= rss_pkg::CounterInFirstReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rss_pkg::CfgHeaderByte:    cfg_q.header_byte <= cfg_data_i;
        rss_pkg::CfgMaxPayloadLen: cfg_q.max_payload_len <= cfg_data_i;
        rss_pkg::CfgCounterFirst:  cfg_q.counter_in_first_byte <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the held event moves on whenever the output register is free.
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.action         <= rss_pkg::action_e'(action_i);
      item_q.tx_role        <= tx_role_i;
      item_q.length         <= length_i;
      item_q.header_value   <= header_value_i;
      item_q.sequence_value <= sequence_value_i;
      item_q.tx_goal        <= tx_goal_i;
      item_q.map_byte_index <= map_byte_index_i;
    end
  end

  // Session logic and bitmap.
  rss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .item_i    (item_q),
    .cfg_i     (cfg_q),
    .status_o  (status),
    .map_ctl_o (map_ctl)
  );

  rss_map #(
    .MAX_SEQUENCE_COUNT (MAX_SEQUENCE_COUNT)
  ) u_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (map_ctl),
    .sel_i      (item_q.map_byte_index),
    .map_byte_o (map_byte)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q   <= status;
      map_byte_q <= map_byte;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign radio_command_o  = status_q.radio_command;
  assign sequence_out_o   = status_q.sequence_out;
  assign session_active_o = status_q.session_active;
  assign rx_count_o       = status_q.rx_count;
  assign rx_try_count_o   = status_q.rx_try_count;
  assign tx_count_o       = status_q.tx_count;
  assign payload_length_o = status_q.payload_length;
  assign rx_rejected_o    = status_q.rx_rejected;
  assign store_payload_o  = status_q.store_payload;
  assign map_byte_o       = map_byte_q;

  // The input side only stalls when both registers are full and blocked.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (item_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  // Keeping the payload only happens on the first good reception.
  a_store_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && store_payload_o) |-> (rx_count_o == 8'd1))
    else $error("store_payload without a first reception");

  // A rejected packet always restarts reception.
  a_reject_rx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rx_rejected_o) |-> (radio_command_o == rss_pkg::CMD_RX))
    else $error("rejection without restarting reception");

endmodule

// ===== sv/rss_map.sv =====
// ----------------------------------------------------------------------------
// rss_map: reception bitmap
// One flip-flop per sequence index. Clears all bits at once, sets one bit per
// event and reports one byte of the bitmap as it stands after the event.
// ----------------------------------------------------------------------------
module rss_map #(
  parameter int unsigned MAX_SEQUENCE_COUNT = rss_pkg::MaxSeqCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rss_pkg::map_ctl_t ctl_i,
  input  logic [4:0]        sel_i,
  output logic [7:0]        map_byte_o
);

  logic [MAX_SEQUENCE_COUNT-1:0] bits_q, bits_d;
  logic [rss_pkg::MapBits-1:0]   window;

  // Next bitmap: a start clears everything, a good reception sets one bit.
  // Indexes at or above the bitmap size match no bit and are dropped.
  always_comb begin
    for (int i = 0; i < MAX_SEQUENCE_COUNT; i++) begin
      if (ctl_i.clear) begin
        bits_d[i] = 1'b0;
      end else if (ctl_i.set && ({1'b0, ctl_i.set_index} == 9'(i))) begin
        bits_d[i] = 1'b1;
      end else begin
        bits_d[i] = bits_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else begin
      bits_q <= bits_d;
    end
  end

  // Read the selected byte of the updated bitmap; the msb is the lowest index.
  always_comb begin
    window = rss_pkg::MapBits'(bits_d);
    for (int k = 0; k < 8; k++) begin
      map_byte_o[7-k] = window[{sel_i, 3'(k)}];
    end
  end

endmodule

// ===== sv/rss_ctrl.sv =====
// ----------------------------------------------------------------------------
// rss_ctrl: session control and counters
// Holds the session flags and counters, decodes one event per fire and
// produces the radio command, the status after the event and the bitmap
// update request.
// ----------------------------------------------------------------------------
module rss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rss_pkg::item_t    item_i,
  input  rss_pkg::cfg_t     cfg_i,
  output rss_pkg::status_t  status_o,
  output rss_pkg::map_ctl_t map_ctl_o
);

  logic       active_q, active_d;
  logic       initiator_q, initiator_d;
  logic [7:0] sent_count_q, sent_count_d;
  logic [7:0] sent_goal_q, sent_goal_d;
  logic [7:0] received_q, received_d;
  logic [7:0] attempt_q, attempt_d;
  logic [7:0] length_q, length_d;

  logic       length_bad;
  logic [7:0] sent_next;
  logic [7:0] recv_next;
  logic [7:0] seq_tx;

  // Length check with exact 9-bit sums.
  assign length_bad =
      ((length_q != 8'd0) &&
       (({1'b0, length_q} + {1'b0, rss_pkg::HeaderLen}) != {1'b0, item_i.length})) ||
      ({1'b0, item_i.length} > ({1'b0, cfg_i.max_payload_len} + {1'b0, rss_pkg::HeaderLen}));

  assign sent_next = sent_count_q + 8'd1;
  assign recv_next = received_q + 8'd1;
  assign seq_tx    = cfg_i.counter_in_first_byte ? sent_count_q : 8'd0;

  // Event decode: next state, command and bitmap request.
  always_comb begin
    active_d    = active_q;
    initiator_d = initiator_q;
    sent_count_d = sent_count_q;
    sent_goal_d = sent_goal_q;
    received_d  = received_q;
    attempt_d   = attempt_q;
    length_d    = length_q;

    status_o.radio_command = rss_pkg::CMD_NONE;
    status_o.sequence_out  = 8'd0;
    status_o.rx_rejected   = 1'b0;
    status_o.store_payload = 1'b0;

    map_ctl_o.clear     = 1'b0;
    map_ctl_o.set       = 1'b0;
    map_ctl_o.set_index = item_i.sequence_value;

    case (item_i.action)
      rss_pkg::ACT_START: begin
        active_d     = 1'b1;
        length_d     = item_i.length;
        received_d   = 8'd0;
        attempt_d    = 8'd0;
        sent_count_d = 8'd0;
        sent_goal_d  = item_i.tx_goal;
        map_ctl_o.clear = fire_i;
        if (item_i.tx_role) begin
          if (item_i.length == 8'd0) begin
            // Nothing to send: the fresh session ends at once.
            active_d = 1'b0;
            status_o.radio_command = rss_pkg::CMD_SLEEP;
          end else begin
            initiator_d = 1'b1;
            status_o.radio_command = rss_pkg::CMD_TX;
          end
        end else begin
          initiator_d = 1'b0;
          status_o.radio_command = rss_pkg::CMD_RX;
        end
      end
      rss_pkg::ACT_STOP: begin
        if (active_q) begin
          active_d = 1'b0;
          status_o.radio_command = rss_pkg::CMD_SLEEP;
        end
      end
      rss_pkg::ACT_RX_STARTED: begin
        attempt_d = attempt_q + 8'd1;
      end
      rss_pkg::ACT_HEADER_RX: begin
        if ((item_i.header_value != cfg_i.header_byte) || length_bad) begin
          status_o.rx_rejected   = 1'b1;
          status_o.radio_command = rss_pkg::CMD_RX;
        end
      end
      rss_pkg::ACT_RX_ENDED: begin
        status_o.radio_command = rss_pkg::CMD_RX;
        if (length_bad) begin
          status_o.rx_rejected = 1'b1;
        end else begin
          length_d      = item_i.length - rss_pkg::HeaderLen;
          map_ctl_o.set = fire_i && cfg_i.counter_in_first_byte;
          received_d    = recv_next;
          status_o.store_payload = (recv_next == 8'd1);
        end
      end
      rss_pkg::ACT_TX_ENDED: begin
        sent_count_d = sent_next;
        if ((sent_next != 8'd0) && (sent_next == sent_goal_q)) begin
          if (active_q) begin
            active_d = 1'b0;
            status_o.radio_command = rss_pkg::CMD_SLEEP;
          end
        end else begin
          status_o.sequence_out  = cfg_i.counter_in_first_byte ? sent_next : 8'd0;
          status_o.radio_command = rss_pkg::CMD_TX;
        end
      end
      rss_pkg::ACT_RXTX_ERROR: begin
        if (active_q) begin
          if (initiator_q) begin
            status_o.sequence_out  = seq_tx;
            status_o.radio_command = rss_pkg::CMD_FLUSH_TX;
          end else begin
            status_o.radio_command = rss_pkg::CMD_FLUSH_RX;
          end
        end
      end
      default: begin
        // Failed reception: listen again.
        status_o.rx_rejected   = 1'b1;
        status_o.radio_command = rss_pkg::CMD_RX;
      end
    endcase

    status_o.session_active = active_d;
    status_o.rx_count       = received_d;
    status_o.rx_try_count   = attempt_d;
    status_o.tx_count       = sent_count_d;
    status_o.payload_length = length_d;
  end

  // Session state registers, updated once per event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      initiator_q  <= 1'b0;
      sent_count_q <= 8'd0;
      sent_goal_q  <= 8'd0;
      received_q   <= 8'd0;
      attempt_q    <= 8'd0;
      length_q     <= 8'd0;
    end else if (fire_i) begin
      active_q     <= active_d;
      initiator_q  <= initiator_d;
      sent_count_q <= sent_count_d;
      sent_goal_q  <= sent_goal_d;
      received_q   <= received_d;
      attempt_q    <= attempt_d;
      length_q     <= length_d;
    end
  end

endmodule
